[src/pmtf_pkg.sv]
// Package for the paged move-to-front key map: table geometry, field codes,
// transaction payload structs. No dependencies.
package pmtf_pkg;

  // Table geometry
  localparam int FIRST_SIZE    = 9;
  localparam int SECOND_SIZE   = 16;
  localparam int THIRD_SIZE    = 9;
  localparam int KEYS_PER_PAGE = 9;

  // All three tables share one memory, laid out back to back
  localparam int FIRST_BASE  = 0;
  localparam int SECOND_BASE = FIRST_SIZE;
  localparam int THIRD_BASE  = FIRST_SIZE + SECOND_SIZE;
  localparam int MEM_DEPTH   = FIRST_SIZE + SECOND_SIZE + THIRD_SIZE;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);

  // Table position: key (4 bits) plus a page offset
  localparam int POS_W = $clog2(16 + KEYS_PER_PAGE);
  // Width for address arithmetic and size compares
  localparam int IDX_W = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;

  // Item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_KEY    = 2'd2;

  // Load banks
  localparam logic [1:0] BANK_FIRST  = 2'd0;
  localparam logic [1:0] BANK_SECOND = 2'd1;
  localparam logic [1:0] BANK_THIRD  = 2'd2;

  // Button codes
  localparam logic [2:0] TAB_FIRST  = 3'd0;
  localparam logic [2:0] TAB_SECOND = 3'd1;
  localparam logic [2:0] TAB_NEXT   = 3'd2;
  localparam logic [2:0] TAB_BACK   = 3'd3;
  localparam logic [2:0] TAB_THIRD  = 3'd4;

  // Active page
  typedef enum logic [1:0] {
    PAGE_FIRST      = 2'd0,
    PAGE_SECOND_ONE = 2'd1,
    PAGE_SECOND_TWO = 2'd2,
    PAGE_THIRD      = 2'd3
  } page_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] bank;
    logic [3:0] entry_index;
    logic [7:0] entry_char;
    logic [2:0] tab_code;
    logic [3:0] key_position;
  } req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic [1:0] page_now;
  } rsp_t;

endpackage

[src/pmtf_req_if.sv]
// Request channel: valid/ready handshake carrying one input item.
// Depends on pmtf_pkg.
interface pmtf_req_if import pmtf_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/pmtf_rsp_if.sv]
// Response channel: valid/ready handshake carrying one result item.
// Depends on pmtf_pkg.
interface pmtf_rsp_if import pmtf_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/paged_move_to_front_key_map.sv]
// Top level of the paged move-to-front key map: table memory, page register,
// shift sequencer and response register. Depends on pmtf_pkg, pmtf_req_if, pmtf_rsp_if.
//
//   port  direction  transaction
//   ----  ---------  ------------------------------------------------
//   req   in         load entry, button/tab or key press
//   rsp   out        character, hit flag and page after the item
//
// Loads, buttons and keys off the table go straight to the response step; a hit at
// table position 0 skips the shift, and a hit at position p > 0 moves p entries
// back one place (p up to 15 at the end of the second table) before the hit
// entry is written to the front, through the one-read one-write table memory.
// req.ready is high only when the sequencer is idle. A stalled response holds
// the sequencer in its last step. Synchronous reset sets the first page;
// table contents are undefined until loaded.
module paged_move_to_front_key_map_core import pmtf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pmtf_req_if.sink    req,
  pmtf_rsp_if.source  rsp
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HIT   = 5'b00010,
    S_SHIFT = 5'b00100,
    S_FRONT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state, state_next;
  page_t             page, page_next;
  logic [ADDR_W-1:0] tab_base, tab_base_next;
  logic [POS_W-1:0]  cur, cur_next;
  logic [7:0]        hit, hit_next;
  logic              hit_ok, hit_ok_next;

  // Table memory
  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // Key and load decode
  logic [ADDR_W-1:0] key_base;
  logic [IDX_W-1:0]  key_size;
  logic [POS_W-1:0]  key_pos;
  logic              key_in_range;
  logic [ADDR_W-1:0] load_base;
  logic [IDX_W-1:0]  load_size;
  logic              load_ok;
  logic              accept;
  logic              rsp_free;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp_free  = !rsp.valid || rsp.ready;

  // Table selection for a key press on the active page
  always_comb begin
    key_pos = POS_W'(req.data.key_position);
    case (page)
      PAGE_FIRST: begin
        key_base = ADDR_W'(FIRST_BASE);
        key_size = IDX_W'(FIRST_SIZE);
      end
      PAGE_SECOND_ONE: begin
        key_base = ADDR_W'(SECOND_BASE);
        key_size = IDX_W'(SECOND_SIZE);
      end
      PAGE_SECOND_TWO: begin
        key_base = ADDR_W'(SECOND_BASE);
        key_size = IDX_W'(SECOND_SIZE);
        key_pos  = POS_W'(req.data.key_position) + POS_W'(KEYS_PER_PAGE);
      end
      default: begin
        key_base = ADDR_W'(THIRD_BASE);
        key_size = IDX_W'(THIRD_SIZE);
      end
    endcase
    key_in_range = IDX_W'(key_pos) < key_size;
  end

  // Table selection for a load
  always_comb begin
    load_ok = 1'b1;
    case (req.data.bank)
      BANK_FIRST: begin
        load_base = ADDR_W'(FIRST_BASE);
        load_size = IDX_W'(FIRST_SIZE);
      end
      BANK_SECOND: begin
        load_base = ADDR_W'(SECOND_BASE);
        load_size = IDX_W'(SECOND_SIZE);
      end
      BANK_THIRD: begin
        load_base = ADDR_W'(THIRD_BASE);
        load_size = IDX_W'(THIRD_SIZE);
      end
      default: begin
        load_base = '0;
        load_size = '0;
        load_ok   = 1'b0;
      end
    endcase
    if (IDX_W'(req.data.entry_index) >= load_size) begin
      load_ok = 1'b0;
    end
  end

  // Sequencer and memory port control
  always_comb begin
    state_next    = state;
    page_next     = page;
    tab_base_next = tab_base;
    cur_next      = cur;
    hit_next      = hit;
    hit_ok_next   = hit_ok;
    mem_we        = 1'b0;
    mem_waddr     = tab_base;
    mem_wdata     = rdata;
    mem_raddr     = ADDR_W'(IDX_W'(key_base) + IDX_W'(key_pos));
    case (state)
      S_IDLE: begin
        if (accept) begin
          hit_ok_next = 1'b0;
          state_next  = S_DONE;
          case (req.data.kind)
            KIND_LOAD: begin
              mem_we    = load_ok;
              mem_waddr = ADDR_W'(IDX_W'(load_base) + IDX_W'(req.data.entry_index));
              mem_wdata = req.data.entry_char;
            end
            KIND_BUTTON: begin
              case (req.data.tab_code)
                TAB_FIRST:  page_next = PAGE_FIRST;
                TAB_SECOND: page_next = PAGE_SECOND_ONE;
                TAB_NEXT:   page_next = (page == PAGE_SECOND_ONE) ? PAGE_SECOND_TWO
                                                                   : PAGE_SECOND_ONE;
                TAB_BACK:   page_next = (page == PAGE_SECOND_TWO) ? PAGE_SECOND_ONE
                                                                   : PAGE_SECOND_TWO;
                TAB_THIRD:  page_next = PAGE_THIRD;
                default:    page_next = page;
              endcase
            end
            KIND_KEY: begin
              // hit entry is read here, lands in rdata next cycle
              if (key_in_range) begin
                hit_ok_next   = 1'b1;
                tab_base_next = key_base;
                cur_next      = key_pos;
                state_next    = S_HIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_HIT: begin
        hit_next  = rdata;
        mem_raddr = ADDR_W'(IDX_W'(tab_base) + IDX_W'(cur) - IDX_W'(1));
        state_next = (cur == '0) ? S_DONE : S_SHIFT;
      end
      S_SHIFT: begin
        // move entry cur-1 back to cur, fetch cur-2 for the next step
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(IDX_W'(tab_base) + IDX_W'(cur));
        mem_wdata = rdata;
        mem_raddr = ADDR_W'(IDX_W'(tab_base) + IDX_W'(cur) - IDX_W'(2));
        if (cur == POS_W'(1)) begin
          state_next = S_FRONT;
        end else begin
          cur_next = cur - POS_W'(1);
        end
      end
      S_FRONT: begin
        mem_we     = 1'b1;
        mem_waddr  = tab_base;
        mem_wdata  = hit;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      page  <= PAGE_FIRST;
    end else begin
      state <= state_next;
      page  <= page_next;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    tab_base <= tab_base_next;
    cur      <= cur_next;
    hit      <= hit_next;
    hit_ok   <= hit_ok_next;
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp.data.char_out   <= hit_ok ? hit : 8'd0;
      rsp.data.char_valid <= hit_ok;
      rsp.data.page_now   <= page;
    end
  end

endmodule
